// ===== src/wrca_pkg.sv =====
// ----------------------------------------------------------------------------
// wrca_pkg
// Shared types, constants and the divider step for the region centroid
// accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package wrca_pkg;

  localparam int NumRegions = 4096;
  localparam int IdxW       = 12;
  localparam int MaxDim     = 1024;
  localparam int DivSteps   = 46;
  localparam int ClearLast  = NumRegions - 1;

  localparam logic [3:0] AddrWidth  = 4'd0;
  localparam logic [3:0] AddrHeight = 4'd4;
  localparam logic [3:0] AddrPoints = 4'd8;

  typedef struct packed {
    logic        req_type;
    logic [23:0] region_label;
    logic [7:0]  gray_level;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic [11:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [11:0] out_index;
    logic        updated;
    logic [18:0] centroid_x;
    logic [18:0] centroid_y;
    logic [27:0] mass;
    logic [7:0]  avg_red;
    logic [7:0]  avg_green;
    logic [7:0]  avg_blue;
  } out_item_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [12:0] num_points;
  } cfg_t;

  typedef enum logic {
    OP_ACC  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [11:0] idx;
    logic [7:0]  w;
    logic [17:0] xp;
    logic [17:0] yp;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } job_t;

  typedef struct packed {
    logic [27:0] ws;
    logic [37:0] xm;
    logic [37:0] ym;
    logic [20:0] pc;
    logic [27:0] rs;
    logic [27:0] gs;
    logic [27:0] bs;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // restoring division step: returns {quotient bit, new remainder}
  function automatic logic [28:0] div_step(logic [27:0] rem, logic in_bit,
                                           logic [27:0] dvs);
    logic [28:0] sh;
    logic [28:0] diff;
    sh   = {rem, in_bit};
    diff = sh - {1'b0, dvs};
    if (sh >= {1'b0, dvs}) begin
      return {1'b1, diff[27:0]};
    end else begin
      return {1'b0, sh[27:0]};
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/wrca_ram.sv =====
// ----------------------------------------------------------------------------
// wrca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wrca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/wrca_front.sv =====
// ----------------------------------------------------------------------------
// wrca_front
// Accepts items, tracks the raster position, drops unused labels and forms
// the weighted moments of each pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module wrca_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire wrca_pkg::cfg_t    cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire wrca_pkg::in_item_t in_data,
  output logic                   push,
  output wrca_pkg::job_t         job,
  input  wire logic              q_full
);
  import wrca_pkg::*;

  logic [9:0]  col;
  logic [9:0]  row;
  logic [10:0] w_eff;
  logic [10:0] h_eff;
  logic [10:0] cx;
  logic [10:0] cy;
  logic [7:0]  wt;
  logic [17:0] px;
  logic [17:0] py;
  logic        accept;
  logic        in_use;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (cfg.image_width == 11'd0) w_eff = 11'd1;
    else if (cfg.image_width > 11'(MaxDim)) w_eff = 11'(MaxDim);
    else w_eff = cfg.image_width;
    if (cfg.image_height == 11'd0) h_eff = 11'd1;
    else if (cfg.image_height > 11'(MaxDim)) h_eff = 11'(MaxDim);
    else h_eff = cfg.image_height;
  end

  assign cx     = {1'b0, col} + 11'd1;
  assign cy     = {1'b0, row} + 11'd1;
  assign wt     = 8'd255 - in_data.gray_level;
  assign px     = {10'd0, wt} * {7'd0, cx};
  assign py     = {10'd0, wt} * {7'd0, cy};
  assign in_use = (in_data.region_label < {11'd0, cfg.num_points}) &&
                  (in_data.region_label < 24'(NumRegions));

  always_comb begin
    job.op  = op_t'(in_data.req_type);
    job.idx = (in_data.req_type == OP_READ) ? in_data.entry_index
                                            : in_data.region_label[IdxW-1:0];
    job.w   = wt;
    job.xp  = px;
    job.yp  = py;
    job.r   = in_data.pixel_red;
    job.g   = in_data.pixel_green;
    job.b   = in_data.pixel_blue;
    push    = accept && ((in_data.req_type == OP_READ) || in_use);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept && (in_data.req_type == OP_ACC)) begin
      if (cx >= w_eff) begin
        col <= '0;
        if (cy >= h_eff) row <= '0;
        else row <= row + 10'd1;
      end else begin
        col <= col + 10'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/wrca_queue.sv =====
// ----------------------------------------------------------------------------
// wrca_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module wrca_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire wrca_pkg::job_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output wrca_pkg::job_t      head
);
  import wrca_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && not_empty) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push && !full} - {1'b0, pop && not_empty};
    end
  end

endmodule

`default_nettype wire

// ===== src/wrca_back.sv =====
// ----------------------------------------------------------------------------
// wrca_back
// Region store with read-modify-write accumulation, readout with
// bit-serial division, and the clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module wrca_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire wrca_pkg::job_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output wrca_pkg::out_item_t out_data
);
  import wrca_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOAD  = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t      state;
  job_t        cur;
  logic [IdxW-1:0] clr_addr;
  logic [5:0]  step;

  logic            we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata;
  entry_t          rdata;

  logic [27:0] m;
  logic [27:0] cnt;
  logic [45:0] dx, dy, dr, dg, db;
  logic [27:0] rx, ry, rr, rg, rb;
  logic [18:0] qx, qy;
  logic [7:0]  qr, qg, qb;
  logic [28:0] sx, sy, sr, sg, sb;
  logic        last_step;

  wrca_ram #(.WIDTH(EntryW), .DEPTH(NumRegions)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (q_head.idx),
    .rdata (rdata)
  );

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);

  always_comb begin
    we    = 1'b0;
    waddr = cur.idx;
    wdata = '0;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
      end
      S_LOAD: begin
        we = 1'b1;
        if (cur.op == OP_ACC) begin
          wdata.ws = rdata.ws + {20'd0, cur.w};
          wdata.xm = rdata.xm + {20'd0, cur.xp};
          wdata.ym = rdata.ym + {20'd0, cur.yp};
          wdata.pc = rdata.pc + 21'd1;
          wdata.rs = rdata.rs + {20'd0, cur.r};
          wdata.gs = rdata.gs + {20'd0, cur.g};
          wdata.bs = rdata.bs + {20'd0, cur.b};
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign sx = div_step(rx, dx[45], m);
  assign sy = div_step(ry, dy[45], m);
  assign sr = div_step(rr, dr[45], cnt);
  assign sg = div_step(rg, dg[45], cnt);
  assign sb = div_step(rb, db[45], cnt);
  assign last_step = (step == 6'(DivSteps - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IdxW'(ClearLast)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) state <= S_LOAD;
        end
        S_LOAD: begin
          state <= (cur.op == OP_ACC) ? S_IDLE : S_DIV;
        end
        S_DIV: begin
          if (last_step) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid) cur <= q_head;
      end
      S_LOAD: begin
        m    <= rdata.ws;
        cnt  <= {7'd0, rdata.pc};
        dx   <= {rdata.xm, 8'd0};
        dy   <= {rdata.ym, 8'd0};
        dr   <= {18'd0, rdata.rs};
        dg   <= {18'd0, rdata.gs};
        db   <= {18'd0, rdata.bs};
        rx   <= '0;
        ry   <= '0;
        rr   <= '0;
        rg   <= '0;
        rb   <= '0;
        step <= '0;
      end
      S_DIV: begin
        dx   <= {dx[44:0], 1'b0};
        dy   <= {dy[44:0], 1'b0};
        dr   <= {dr[44:0], 1'b0};
        dg   <= {dg[44:0], 1'b0};
        db   <= {db[44:0], 1'b0};
        rx   <= sx[27:0];
        ry   <= sy[27:0];
        rr   <= sr[27:0];
        rg   <= sg[27:0];
        rb   <= sb[27:0];
        qx   <= {qx[17:0], sx[28]};
        qy   <= {qy[17:0], sy[28]};
        qr   <= {qr[6:0], sr[28]};
        qg   <= {qg[6:0], sg[28]};
        qb   <= {qb[6:0], sb[28]};
        step <= step + 6'd1;
        if (last_step) begin
          out_data.out_index <= cur.idx;
          out_data.updated   <= (m != '0);
          out_data.mass      <= m;
          if (m != '0) begin
            out_data.centroid_x <= {qx[17:0], sx[28]};
            out_data.centroid_y <= {qy[17:0], sy[28]};
          end else begin
            out_data.centroid_x <= '0;
            out_data.centroid_y <= '0;
          end
          if ((m != '0) && (cnt != '0)) begin
            out_data.avg_red   <= {qr[6:0], sr[28]};
            out_data.avg_green <= {qg[6:0], sg[28]};
            out_data.avg_blue  <= {qb[6:0], sb[28]};
          end else begin
            out_data.avg_red   <= '0;
            out_data.avg_green <= '0;
            out_data.avg_blue  <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/weighted_region_centroid_accumulator.sv =====
// ----------------------------------------------------------------------------
// weighted_region_centroid_accumulator
// Per-region weighted centroid, mass and mean color for one relaxation pass.
// ----------------------------------------------------------------------------
// After reset all 4096 entries of the region store are cleared, during
// which no input transaction is taken past the two-entry queue. A pixel that
// lands in an active region passes the store's read-modify-write loop
// through the load state; a pixel with an unused label is dropped at the
// input. A readout loads its entry, runs the bit-serial divider (one quotient
// bit per cycle for all five quotients) and holds its result in the output
// state for as long as the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_region_centroid_accumulator (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire wrca_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output wrca_pkg::out_item_t      out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import wrca_pkg::*;

  cfg_t cfg;
  logic push;
  job_t job;
  logic q_full;
  logic q_pop;
  logic q_valid;
  job_t q_head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= 11'd1024;
      cfg.image_height <= 11'd1024;
      cfg.num_points   <= 13'd4096;
    end else if (psel && penable && pwrite) begin
      case ({paddr[3:2], 2'b00})
        AddrWidth:  cfg.image_width  <= pwdata[10:0];
        AddrHeight: cfg.image_height <= pwdata[10:0];
        AddrPoints: cfg.num_points   <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case ({paddr[3:2], 2'b00})
      AddrWidth:  prdata = {21'd0, cfg.image_width};
      AddrHeight: prdata = {21'd0, cfg.image_height};
      AddrPoints: prdata = {19'd0, cfg.num_points};
      default:    prdata = '0;
    endcase
  end

  wrca_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .job      (job),
    .q_full   (q_full)
  );

  wrca_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  wrca_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: weighted region centroid accumulator testbench
// Drives pixel and readout transactions with random idling on both sides,
// predicts every readout from a local model of the region store and the
// raster position, and compares results field by field. Registers are
// written over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import wrca_pkg::*;

  localparam int RegionCount = 4096;
  localparam int DimLimit    = 1024;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  out_item_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  weighted_region_centroid_accumulator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [27:0] ws_q [RegionCount];
  logic [37:0] xm_q [RegionCount];
  logic [37:0] ym_q [RegionCount];
  logic [20:0] pc_q [RegionCount];
  logic [27:0] rs_q [RegionCount];
  logic [27:0] gs_q [RegionCount];
  logic [27:0] bs_q [RegionCount];
  logic [10:0] width_q = 11'd1024, height_q = 11'd1024;
  logic [12:0] points_q = 13'd4096;
  int unsigned col_q = 0, row_q = 0;

  out_item_t pending_centroids[$];
  int errors = 0;
  int readouts = 0;
  int pixels = 0;
  bit hold_off = 1'b0;

  function automatic int unsigned clamp_dim(logic [10:0] v);
    if (v == 0) return 1;
    if (v > DimLimit) return DimLimit;
    return v;
  endfunction

  function automatic out_item_t region_result(in_item_t it);
    out_item_t r;
    logic [27:0] m;
    logic [45:0] qx, qy;
    r = '0;
    r.out_index = it.entry_index;
    m = ws_q[it.entry_index];
    if (m != 0) begin
      qx = {xm_q[it.entry_index], 8'd0} / m;
      qy = {ym_q[it.entry_index], 8'd0} / m;
      r.updated = 1'b1;
      r.centroid_x = qx[18:0];
      r.centroid_y = qy[18:0];
      r.mass = m;
      if (pc_q[it.entry_index] != 0) begin
        r.avg_red   = 8'(rs_q[it.entry_index] / pc_q[it.entry_index]);
        r.avg_green = 8'(gs_q[it.entry_index] / pc_q[it.entry_index]);
        r.avg_blue  = 8'(bs_q[it.entry_index] / pc_q[it.entry_index]);
      end
    end
    return r;
  endfunction

  // returns 1 when a result is expected
  function automatic bit apply_item(in_item_t it, output out_item_t r);
    int unsigned i, w, wd, ht;
    r = '0;
    if (op_t'(it.req_type) == OP_READ) begin
      i = it.entry_index;
      r = region_result(it);
      ws_q[i] = 0; xm_q[i] = 0; ym_q[i] = 0; pc_q[i] = 0;
      rs_q[i] = 0; gs_q[i] = 0; bs_q[i] = 0;
      return 1'b1;
    end
    if (it.region_label < points_q && it.region_label < RegionCount) begin
      i = it.region_label;
      w = 255 - it.gray_level;
      ws_q[i] = ws_q[i] + 28'(w);
      xm_q[i] = xm_q[i] + 38'(w * (col_q + 1));
      ym_q[i] = ym_q[i] + 38'(w * (row_q + 1));
      pc_q[i] = pc_q[i] + 21'd1;
      rs_q[i] = rs_q[i] + 28'(it.pixel_red);
      gs_q[i] = gs_q[i] + 28'(it.pixel_green);
      bs_q[i] = bs_q[i] + 28'(it.pixel_blue);
    end
    wd = clamp_dim(width_q);
    ht = clamp_dim(height_q);
    if (col_q + 1 >= wd) begin
      col_q = 0;
      row_q = (row_q + 1 >= ht) ? 0 : row_q + 1;
    end else begin
      col_q++;
    end
    return 1'b0;
  endfunction

  task automatic send(in_item_t it);
    out_item_t r;
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (apply_item(it, r)) pending_centroids = {pending_centroids, r};
    else pixels++;
  endtask

  task automatic send_checked(in_item_t it, out_item_t want);
    out_item_t r;
    r = region_result(it);
    if (r != want) begin
      $error("directed row: table value %h differs from prediction %h", want, r);
      errors++;
    end
    send(it);
  endtask

  task automatic apb_write(logic [3:0] a, logic [31:0] d);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_centroids.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  task automatic configure(logic [10:0] w, logic [10:0] h, logic [12:0] p);
    drain();
    apb_write(AddrWidth, 32'(w));
    apb_write(AddrHeight, 32'(h));
    apb_write(AddrPoints, 32'(p));
    width_q = w; height_q = h; points_q = p;
  endtask

  function automatic in_item_t pixel(logic [23:0] lbl, logic [7:0] g,
                                     logic [7:0] r, logic [7:0] gr, logic [7:0] b);
    in_item_t it;
    it = '0;
    it.req_type = OP_ACC;
    it.region_label = lbl; it.gray_level = g;
    it.pixel_red = r; it.pixel_green = gr; it.pixel_blue = b;
    it.entry_index = 12'($urandom());
    return it;
  endfunction

  function automatic in_item_t readout(logic [11:0] idx);
    in_item_t it;
    logic [95:0] noise;
    noise = {$urandom(), $urandom(), $urandom()};
    it = noise[$bits(in_item_t)-1:0];
    it.req_type = OP_READ;
    it.entry_index = idx;
    return it;
  endfunction

  function automatic in_item_t random_item(int unsigned regions);
    in_item_t it;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 12) return readout(12'($urandom_range(0, regions - 1)));
    if (k < 14) return readout(12'($urandom()));
    if (k < 20) return pixel(24'($urandom()), 8'($urandom()), 8'($urandom()),
                             8'($urandom()), 8'($urandom()));
    it = pixel(24'($urandom_range(0, regions - 1)), 8'($urandom()), 8'($urandom()),
               8'($urandom()), 8'($urandom()));
    if ($urandom_range(0, 9) == 0) it.gray_level = 8'd255;
    return it;
  endfunction

  typedef struct {
    in_item_t   item;
    bit         fixed;
    out_item_t  want;
  } directed_row_t;

  // result side
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_centroids.size() == 0) begin
        $error("unexpected result for region %0d", out_data.out_index);
        errors++;
      end else begin
        e = pending_centroids.pop_front();
        readouts++;
        if (out_data.out_index != e.out_index) begin
          $error("out_index expected %0d actual %0d", e.out_index, out_data.out_index);
          errors++;
        end
        if (out_data.updated != e.updated) begin
          $error("updated expected %0d actual %0d", e.updated, out_data.updated);
          errors++;
        end
        if (out_data.centroid_x != e.centroid_x) begin
          $error("centroid_x expected %0d actual %0d", e.centroid_x, out_data.centroid_x);
          errors++;
        end
        if (out_data.centroid_y != e.centroid_y) begin
          $error("centroid_y expected %0d actual %0d", e.centroid_y, out_data.centroid_y);
          errors++;
        end
        if (out_data.mass != e.mass) begin
          $error("mass expected %0d actual %0d", e.mass, out_data.mass);
          errors++;
        end
        if (out_data.avg_red != e.avg_red) begin
          $error("avg_red expected %0d actual %0d", e.avg_red, out_data.avg_red);
          errors++;
        end
        if (out_data.avg_green != e.avg_green) begin
          $error("avg_green expected %0d actual %0d", e.avg_green, out_data.avg_green);
          errors++;
        end
        if (out_data.avg_blue != e.avg_blue) begin
          $error("avg_blue expected %0d actual %0d", e.avg_blue, out_data.avg_blue);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      n = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    out_item_t empty;
    int unsigned regions;
    for (int i = 0; i < RegionCount; i++) begin
      ws_q[i] = 0; xm_q[i] = 0; ym_q[i] = 0; pc_q[i] = 0;
      rs_q[i] = 0; gs_q[i] = 0; bs_q[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; empty regions read as all zero
    empty = '0;
    row.fixed = 1; row.item = readout(12'd0); row.want = empty; rows = {rows, row};
    empty.out_index = 12'd4095;
    row.item = readout(12'd4095); row.want = empty; rows = {rows, row};
    row.fixed = 0;
    row.item = pixel(24'd0, 8'd0, 8'd255, 8'd255, 8'd255); rows = {rows, row};
    row.item = pixel(24'd0, 8'd255, 8'd0, 8'd0, 8'd0); rows = {rows, row};
    row.item = pixel(24'd4095, 8'd0, 8'd170, 8'd85, 8'd1); rows = {rows, row};
    row.item = pixel(24'hFFFFFF, 8'd0, 8'd9, 8'd9, 8'd9); rows = {rows, row};
    row.item = pixel(24'd4096, 8'd10, 8'd9, 8'd9, 8'd9); rows = {rows, row};
    row.item = pixel(24'd7, 8'd255, 8'd200, 8'd100, 8'd50); rows = {rows, row};
    row.item = readout(12'd0); rows = {rows, row};
    row.item = readout(12'd4095); rows = {rows, row};
    row.item = readout(12'd7); rows = {rows, row};
    row.item = readout(12'd0); rows = {rows, row};
    foreach (rows[i]) begin
      if (rows[i].fixed) send_checked(rows[i].item, rows[i].want);
      else send(rows[i].item);
    end

    // small image, few regions: raster wrap and skipped labels
    configure(11'd3, 11'd2, 13'd5);
    for (int i = 0; i < 14; i++)
      send(pixel(24'($urandom_range(0, 7)), 8'($urandom()), 8'($urandom()),
                 8'($urandom()), 8'($urandom())));
    for (int i = 0; i < 8; i++) send(readout(12'(i)));

    // out of range dimensions clamp; counter beyond shrunken size
    configure(11'd0, 11'd2047, 13'd8191);
    for (int i = 0; i < 5; i++) send(pixel(24'd1, 8'd0, 8'd1, 8'd2, 8'd3));
    send(readout(12'd1));
    configure(11'd1024, 11'd1, 13'd1);
    for (int i = 0; i < 4; i++) send(pixel(24'(i % 2), 8'd3, 8'd4, 8'd5, 8'd6));
    send(readout(12'd0));
    send(readout(12'd1));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: configure(11'd16, 11'd8, 13'd8);
        1: configure(11'($urandom_range(1, 2047)), 11'($urandom_range(0, 2047)), 13'd16);
        2: configure(11'd1024, 11'd1024, 13'd4096);
        default: configure(11'd1, 11'd1, 13'($urandom_range(0, 40)));
      endcase
      regions = (phase == 2) ? 24 : 16;
      for (int i = 0; i < 125; i++) begin
        if (phase == 1 && i == 40) hold_off = 1'b1;
        send(random_item(regions));
      end
      for (int i = 0; i < regions; i++) send(readout(12'(i)));
    end

    drain();
    $display("covered %0d pixel and %0d readout transactions over several register settings",
             pixels, readouts);
    if (errors == 0 && pending_centroids.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/wrca_pkg.sv
src/wrca_ram.sv
src/wrca_front.sv
src/wrca_queue.sv
src/wrca_back.sv
src/weighted_region_centroid_accumulator.sv
dv/tb.sv
